FILE: rtl/core/two_class_job_queue_assert.svh
// Assertion macros for the two-class job queue.
// Used by two_class_job_queue.sv; needs i_clk and i_rst_n in scope.
`ifndef TWO_CLASS_JOB_QUEUE_ASSERT_SVH
`define TWO_CLASS_JOB_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TCJQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define TCJQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcjq_pkg.sv
// Package for the two-class job queue: sizes, codes and FSM states.
// No dependencies; imported by the interfaces and the top level.
package tcjq_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int PTR_W     = IDX_W + 1;

    localparam int CMD_W     = 3;
    localparam int ID_W      = 20;
    localparam int PG_W      = 17;
    localparam int STS_W     = 3;
    localparam int CNT_W     = 7;
    localparam int TOT_W     = 23;

    localparam logic [PTR_W-1:0] NIL       = PTR_W'(CAPACITY);
    localparam logic [ID_W-1:0]  ID_MAX    = ID_W'(999999);
    localparam logic [PG_W-1:0]  PAGES_MAX = PG_W'(99999);

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SERVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STS_W-1:0] ST_DUP       = 3'd3;
    localparam logic [STS_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_SERVE_RD,
        S_CHECK,
        S_ALLOC_RD,
        S_WR_ENTRY,
        S_WR_LINK,
        S_UNLINK_A,
        S_UNLINK_B,
        S_RESP
    } t_state;

endpackage

FILE: rtl/core/tcjq_if.sv
// Valid/ready channel interfaces for the job queue: commands in, results out.
// Depends on tcjq_pkg for field widths.
interface tcjq_cmd_if import tcjq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  job_id;
    logic [PG_W-1:0]  page_count;
    logic             urgent;

    modport source (output valid, cmd, job_id, page_count, urgent, input ready);
    modport sink   (input valid, cmd, job_id, page_count, urgent, output ready);
endinterface

interface tcjq_res_if import tcjq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic [ID_W-1:0]  out_id;
    logic [PG_W-1:0]  out_pages;
    logic             out_urgent;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] urgent_count;
    logic [CNT_W-1:0] normal_count;
    logic [TOT_W-1:0] pending_pages;

    modport source (output valid, status, out_id, out_pages, out_urgent, position,
                    urgent_count, normal_count, pending_pages, input ready);
    modport sink   (input valid, status, out_id, out_pages, out_urgent, position,
                    urgent_count, normal_count, pending_pages, output ready);
endinterface

FILE: rtl/core/two_class_job_queue.sv
// Two-class job queue: linked lists in an entry RAM and a link RAM, one FSM.
// Depends on tcjq_pkg, tcjq_if.sv and two_class_job_queue_assert.svh.
//
//  channel | dir | transfer when
//  i_cmd   | in  | i_cmd.valid && i_cmd.ready
//  o_res   | out | o_res.valid && o_res.ready
//
// One command at a time. Serve reads the head job, then unlinks it and frees its slot;
// clear, unused codes and commands refused at once go straight to the result state.
// Find, cancel and add walk the urgent then the normal list, one RAM read per cycle.
// Reset is synchronous and empties both lists at once; no RAM sweep is needed.
// A result waiting in the output register holds the FSM in its result state when the
// next result is ready, so that result is not loaded until the waiting one transfers.
`include "two_class_job_queue_assert.svh"

module two_class_job_queue import tcjq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcjq_cmd_if.sink   i_cmd,
    tcjq_res_if.source o_res
);

    // entry RAM {id, pages} and link RAM
    logic [ID_W+PG_W-1:0] r_dat_mem [CAPACITY];
    logic [PTR_W-1:0]     r_lnk_mem [CAPACITY];
    logic [ID_W+PG_W-1:0] r_rd_dat;
    logic [PTR_W-1:0]     r_rd_lnk;

    logic                 dat_we, lnk_we;
    logic [IDX_W-1:0]     dat_wa, lnk_wa, rd_addr;
    logic [ID_W+PG_W-1:0] dat_wd;
    logic [PTR_W-1:0]     lnk_wd;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [ID_W-1:0]  r_id, n_id, r_max, n_max;
    logic [PG_W-1:0]  r_pg, n_pg;
    logic             r_urg, n_urg, r_list, n_list, r_walk_max, n_walk_max;
    logic [IDX_W-1:0] r_cur, n_cur, r_slot, n_slot;
    logic [PTR_W-1:0] r_prev, n_prev, r_nxt, n_nxt;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [PTR_W-1:0] r_uhead, n_uhead, r_utail, n_utail;
    logic [PTR_W-1:0] r_nhead, n_nhead, r_ntail, n_ntail;
    logic [PTR_W-1:0] r_free_head, n_free_head, r_fresh, n_fresh;
    logic [CNT_W-1:0] r_ucnt, n_ucnt, r_ncnt, n_ncnt;
    logic [TOT_W-1:0] r_total, n_total;

    logic [STS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic [PG_W-1:0]  r_res_pg, n_res_pg;
    logic             r_res_urg, n_res_urg;
    logic [CNT_W-1:0] r_res_pos, n_res_pos;

    logic             r_out_valid, n_out_valid;
    logic [STS_W-1:0] r_o_status;
    logic [ID_W-1:0]  r_o_id;
    logic [PG_W-1:0]  r_o_pg;
    logic             r_o_urg;
    logic [CNT_W-1:0] r_o_pos, r_o_ucnt, r_o_ncnt;
    logic [TOT_W-1:0] r_o_total;

    logic [ID_W-1:0]  rd_id;
    logic [PG_W-1:0]  rd_pg;
    logic [PTR_W-1:0] cur_head, add_tail;
    logic             walk_done, no_space, out_load;

    assign rd_id    = r_rd_dat[ID_W+PG_W-1:PG_W];
    assign rd_pg    = r_rd_dat[PG_W-1:0];
    assign cur_head = r_list ? r_nhead : r_uhead;
    assign add_tail = r_urg ? r_utail : r_ntail;
    assign no_space = (r_free_head == NIL) && (r_fresh == NIL);
    assign out_load = (r_state == S_RESP) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            r_dat_mem[dat_wa] <= dat_wd;
        end
        r_rd_dat <= r_dat_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            r_lnk_mem[lnk_wa] <= lnk_wd;
        end
        r_rd_lnk <= r_lnk_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_max       = r_max;
        n_pg        = r_pg;
        n_urg       = r_urg;
        n_list      = r_list;
        n_walk_max  = r_walk_max;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_pos       = r_pos;
        n_uhead     = r_uhead;
        n_utail     = r_utail;
        n_nhead     = r_nhead;
        n_ntail     = r_ntail;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_ucnt      = r_ucnt;
        n_ncnt      = r_ncnt;
        n_total     = r_total;
        n_status    = r_status;
        n_res_id    = r_res_id;
        n_res_pg    = r_res_pg;
        n_res_urg   = r_res_urg;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        dat_we      = 1'b0;
        dat_wa      = r_slot;
        dat_wd      = {r_id, r_pg};
        lnk_we      = 1'b0;
        lnk_wa      = r_slot;
        lnk_wd      = NIL;
        rd_addr     = r_cur;
        walk_done   = 1'b0;
        i_cmd.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd      = i_cmd.cmd;
                    n_id       = i_cmd.job_id;
                    n_urg      = i_cmd.urgent;
                    n_list     = 1'b0;
                    n_walk_max = 1'b0;
                    n_max      = '0;
                    n_status   = ST_OK;
                    n_res_id   = '0;
                    n_res_pg   = '0;
                    n_res_urg  = 1'b0;
                    n_res_pos  = '0;
                    if (i_cmd.page_count == '0) begin
                        n_pg = PG_W'(1);
                    end else if (i_cmd.page_count > PAGES_MAX) begin
                        n_pg = PAGES_MAX;
                    end else begin
                        n_pg = i_cmd.page_count;
                    end
                    n_state = S_RESP;
                    priority case (i_cmd.cmd)
                        CMD_ADD: begin
                            if (i_cmd.job_id == '0) begin
                                n_walk_max = 1'b1;
                                n_state    = S_START;
                            end else if (i_cmd.job_id > ID_MAX) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_START;
                            end
                        end
                        CMD_SERVE, CMD_FIND, CMD_CANCEL: begin
                            if (r_ucnt == '0 && r_ncnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_cmd.cmd == CMD_SERVE) begin
                                n_list  = (r_uhead == NIL);
                                n_cur   = (r_uhead != NIL) ? r_uhead[IDX_W-1:0]
                                                           : r_nhead[IDX_W-1:0];
                                rd_addr = n_cur;
                                n_prev  = NIL;
                                n_state = S_SERVE_RD;
                            end else begin
                                n_state = S_START;
                            end
                        end
                        CMD_CLEAR: begin
                            n_uhead     = NIL;
                            n_utail     = NIL;
                            n_nhead     = NIL;
                            n_ntail     = NIL;
                            n_ucnt      = '0;
                            n_ncnt      = '0;
                            n_total     = '0;
                            n_free_head = NIL;
                            n_fresh     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                if (cur_head == NIL) begin
                    walk_done = 1'b1;
                end else begin
                    n_cur   = cur_head[IDX_W-1:0];
                    rd_addr = n_cur;
                    n_prev  = NIL;
                    n_pos   = CNT_W'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!r_walk_max && rd_id == r_id) begin
                    if (r_cmd == CMD_ADD) begin
                        n_status = ST_DUP;
                        n_state  = S_RESP;
                    end else begin
                        n_res_id  = rd_id;
                        n_res_pg  = rd_pg;
                        n_res_urg = !r_list;
                        if (r_cmd == CMD_FIND) begin
                            n_res_pos = r_pos;
                            n_state   = S_RESP;
                        end else begin
                            n_slot  = r_cur;
                            n_nxt   = r_rd_lnk;
                            n_state = S_UNLINK_A;
                        end
                    end
                end else begin
                    if (r_walk_max && rd_id > r_max) begin
                        n_max = rd_id;
                    end
                    if (r_rd_lnk == NIL) begin
                        walk_done = 1'b1;
                    end else begin
                        n_prev  = {1'b0, r_cur};
                        n_cur   = r_rd_lnk[IDX_W-1:0];
                        rd_addr = n_cur;
                        n_pos   = r_pos + CNT_W'(1);
                    end
                end
            end
            S_SERVE_RD: begin
                n_res_id  = rd_id;
                n_res_pg  = rd_pg;
                n_res_urg = !r_list;
                n_slot    = r_cur;
                n_nxt     = r_rd_lnk;
                n_state   = S_UNLINK_A;
            end
            S_CHECK: begin
                if (no_space) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else if (r_free_head != NIL) begin
                    n_slot  = r_free_head[IDX_W-1:0];
                    rd_addr = n_slot;
                    n_state = S_ALLOC_RD;
                end else begin
                    n_slot  = r_fresh[IDX_W-1:0];
                    n_fresh = r_fresh + PTR_W'(1);
                    n_state = S_WR_ENTRY;
                end
            end
            S_ALLOC_RD: begin
                n_free_head = r_rd_lnk;
                n_state     = S_WR_ENTRY;
            end
            S_WR_ENTRY: begin
                dat_we  = 1'b1;
                lnk_we  = 1'b1;
                n_state = S_WR_LINK;
            end
            S_WR_LINK: begin
                if (add_tail != NIL) begin
                    lnk_we = 1'b1;
                    lnk_wa = add_tail[IDX_W-1:0];
                    lnk_wd = {1'b0, r_slot};
                end
                if (r_urg) begin
                    if (r_utail == NIL) n_uhead = {1'b0, r_slot};
                    n_utail = {1'b0, r_slot};
                    n_ucnt  = r_ucnt + CNT_W'(1);
                end else begin
                    if (r_ntail == NIL) n_nhead = {1'b0, r_slot};
                    n_ntail = {1'b0, r_slot};
                    n_ncnt  = r_ncnt + CNT_W'(1);
                end
                n_total   = r_total + TOT_W'(r_pg);
                n_res_id  = r_id;
                n_res_pg  = r_pg;
                n_res_urg = r_urg;
                n_state   = S_RESP;
            end
            S_UNLINK_A: begin
                if (r_prev != NIL) begin
                    lnk_we = 1'b1;
                    lnk_wa = r_prev[IDX_W-1:0];
                    lnk_wd = r_nxt;
                end
                if (r_res_urg) begin
                    if (r_prev == NIL) n_uhead = r_nxt;
                    if (r_utail == {1'b0, r_slot}) n_utail = r_prev;
                    n_ucnt = r_ucnt - CNT_W'(1);
                end else begin
                    if (r_prev == NIL) n_nhead = r_nxt;
                    if (r_ntail == {1'b0, r_slot}) n_ntail = r_prev;
                    n_ncnt = r_ncnt - CNT_W'(1);
                end
                n_total = r_total - TOT_W'(r_res_pg);
                n_state = S_UNLINK_B;
            end
            S_UNLINK_B: begin
                lnk_we      = 1'b1;
                lnk_wd      = r_free_head;
                n_free_head = {1'b0, r_slot};
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // end of one list: go on to the normal list or conclude the walk
        if (walk_done) begin
            if (!r_list) begin
                n_list  = 1'b1;
                n_state = S_START;
            end else if (r_walk_max) begin
                if (n_max >= ID_MAX) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_id    = n_max + ID_W'(1);
                    n_state = S_CHECK;
                end
            end else if (r_cmd == CMD_ADD) begin
                n_state = S_CHECK;
            end else begin
                n_status = ST_NOT_FOUND;
                n_state  = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_uhead     <= NIL;
            r_utail     <= NIL;
            r_nhead     <= NIL;
            r_ntail     <= NIL;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_ucnt      <= '0;
            r_ncnt      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_uhead     <= n_uhead;
            r_utail     <= n_utail;
            r_nhead     <= n_nhead;
            r_ntail     <= n_ntail;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_ucnt      <= n_ucnt;
            r_ncnt      <= n_ncnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_max      <= n_max;
        r_pg       <= n_pg;
        r_urg      <= n_urg;
        r_list     <= n_list;
        r_walk_max <= n_walk_max;
        r_cur      <= n_cur;
        r_slot     <= n_slot;
        r_prev     <= n_prev;
        r_nxt      <= n_nxt;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_pg   <= n_res_pg;
        r_res_urg  <= n_res_urg;
        r_res_pos  <= n_res_pos;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_id     <= r_res_id;
            r_o_pg     <= r_res_pg;
            r_o_urg    <= r_res_urg;
            r_o_pos    <= r_res_pos;
            r_o_ucnt   <= r_ucnt;
            r_o_ncnt   <= r_ncnt;
            r_o_total  <= r_total;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.out_id        = r_o_id;
    assign o_res.out_pages     = r_o_pg;
    assign o_res.out_urgent    = r_o_urg;
    assign o_res.position      = r_o_pos;
    assign o_res.urgent_count  = r_o_ucnt;
    assign o_res.normal_count  = r_o_ncnt;
    assign o_res.pending_pages = r_o_total;

    `TCJQ_ASSERT_IMP(a_cnt_cap, 1'b1,
        ({1'b0, r_ucnt} + {1'b0, r_ncnt} <= (CNT_W+1)'(CAPACITY)), "job count over capacity")
    `TCJQ_ASSERT_IMP(a_uhead, r_state == S_IDLE,
        ((r_uhead == NIL) == (r_ucnt == '0)), "urgent head and count disagree")
    `TCJQ_ASSERT_IMP(a_nhead, r_state == S_IDLE,
        ((r_nhead == NIL) == (r_ncnt == '0)), "normal head and count disagree")
    `TCJQ_ASSERT_IMP(a_err_zero, (r_state == S_RESP) && (r_status != ST_OK),
        (r_res_id == '0) && (r_res_pos == '0), "error result carries job fields")
    `TCJQ_ASSERT_NXT(a_busy, i_cmd.valid && i_cmd.ready,
        r_state != S_IDLE, "command transfer did not start work")

endmodule
